[design/pcifd_pkg.sv]
// Shared types, codes and the opcode table lookup for the instruction field decoder.
package pcifd_pkg;

    localparam int WIN_W = 67;

    typedef enum logic [3:0] {
        MODE_OPCODE    = 4'd0,
        MODE_REGISTER  = 4'd1,
        MODE_DIRECTION = 4'd2,
        MODE_CONDITION = 4'd3,
        MODE_ADDRESS   = 4'd4,
        MODE_ZCONST    = 4'd5,
        MODE_SCONST    = 4'd6,
        MODE_SHIFT     = 4'd7,
        MODE_SIZE      = 4'd8,
        MODE_POINTER   = 4'd9
    } mode_t;

    localparam logic [6:0] SZ_NONE  = 7'd0;
    localparam logic [6:0] SZ_BIT   = 7'd1;
    localparam logic [6:0] SZ_BYTE  = 7'd8;
    localparam logic [6:0] SZ_HALF  = 7'd16;
    localparam logic [6:0] SZ_WORD  = 7'd32;
    localparam logic [6:0] SZ_DWORD = 7'd64;

    typedef struct packed {
        logic [6:0]  used;
        logic [6:0]  psize;
        logic        sign_ext;
        logic [6:0]  small_val;
        logic [63:0] raw;
    } decode_t;

    typedef struct packed {
        logic [5:0] id;
        logic [6:0] len;
    } opcode_t;

    function automatic opcode_t opcode_lookup(input logic [6:0] code);
        opcode_t r;
        logic [6:0] rel;
        rel = 7'd0;
        priority if (code < 7'd64) begin
            r.id  = {3'b000, code[5:3]};
            r.len = 7'd4;
        end
        else if (code < 7'd72) begin
            r.id  = 6'd8;
            r.len = 7'd4;
        end
        else if (code < 7'd76) begin
            r.id  = 6'd9;
            r.len = 7'd5;
        end
        else if (code < 7'd80) begin
            r.id  = 6'd10;
            r.len = 7'd5;
        end
        else if (code < 7'd88) begin
            r.id  = 6'd11;
            r.len = 7'd4;
        end
        else if (code < 7'd96) begin
            r.id  = 6'd12;
            r.len = 7'd4;
        end
        else if (code < 7'd112) begin
            rel   = code - 7'd96;
            r.id  = 6'd13 + {3'b000, rel[3:1]};
            r.len = 7'd6;
        end
        else begin
            rel   = code - 7'd112;
            r.id  = 6'd21 + {2'b00, rel[3:0]};
            r.len = 7'd7;
        end
        return r;
    endfunction

endpackage

[design/pcifd_decode.sv]
// Field decode: opcode lookup, header parse and payload alignment.
module pcifd_decode (
    input  logic [3:0]                  mode,
    input  logic [pcifd_pkg::WIN_W-1:0] window,
    output pcifd_pkg::decode_t          dec
);

    pcifd_pkg::opcode_t op;
    logic [2:0]  head;
    logic [1:0]  off;
    logic [63:0] aligned;

    assign op   = pcifd_pkg::opcode_lookup(window[66:60]);
    assign head = window[66:64];

    always_comb
    begin
        unique case (off)
            2'd1:    aligned = window[65:2];
            2'd2:    aligned = window[64:1];
            default: aligned = window[63:0];
        endcase
    end

    always_comb
    begin
        dec           = '0;
        off           = 2'd3;
        dec.raw       = aligned;
        unique case (pcifd_pkg::mode_t'(mode))
            pcifd_pkg::MODE_OPCODE:
            begin
                dec.small_val = {1'b0, op.id};
                dec.used      = op.len;
            end
            pcifd_pkg::MODE_REGISTER, pcifd_pkg::MODE_CONDITION:
            begin
                dec.small_val = {4'b0, head};
                dec.used      = 7'd3;
            end
            pcifd_pkg::MODE_DIRECTION:
            begin
                dec.small_val = {6'b0, head[2]};
                dec.used      = 7'd1;
            end
            pcifd_pkg::MODE_POINTER:
            begin
                dec.small_val = {5'b0, head[2:1]};
                dec.used      = 7'd2;
            end
            pcifd_pkg::MODE_SHIFT:
            begin
                if (window[66])
                begin
                    dec.small_val = 7'd1;
                    dec.used      = 7'd1;
                end
                else
                begin
                    dec.small_val = {1'b0, window[65:60]};
                    dec.used      = 7'd7;
                end
            end
            pcifd_pkg::MODE_SIZE:
            begin
                if (!head[2])
                begin
                    dec.small_val = head[1] ? 7'd4 : 7'd1;
                    dec.used      = 7'd2;
                end
                else
                begin
                    dec.small_val = 7'd8 << head[1:0];
                    dec.used      = 7'd3;
                end
            end
            pcifd_pkg::MODE_ADDRESS, pcifd_pkg::MODE_ZCONST, pcifd_pkg::MODE_SCONST:
            begin
                dec.sign_ext = (pcifd_pkg::mode_t'(mode) != pcifd_pkg::MODE_ZCONST);
                priority if (!head[2])
                begin
                    off       = 2'd1;
                    dec.psize = (pcifd_pkg::mode_t'(mode) == pcifd_pkg::MODE_ADDRESS)
                                ? pcifd_pkg::SZ_BYTE : pcifd_pkg::SZ_BIT;
                end
                else if (!head[1])
                begin
                    off       = 2'd2;
                    dec.psize = (pcifd_pkg::mode_t'(mode) == pcifd_pkg::MODE_ADDRESS)
                                ? pcifd_pkg::SZ_HALF : pcifd_pkg::SZ_BYTE;
                end
                else
                begin
                    off       = 2'd3;
                    dec.psize = head[0] ? pcifd_pkg::SZ_DWORD : pcifd_pkg::SZ_WORD;
                end
                dec.used = {5'b0, off} + dec.psize;
            end
            default:
            begin
                dec.used = 7'd0;
            end
        endcase
    end

endmodule

[design/prefix_coded_instruction_field_decoder.sv]
// Top level of the prefix-coded instruction field decoder.
//
// Usage: present one field per transaction on the slave stream. s_axis_tuser
// carries the field kind; s_axis_tdata carries the bit position and the
// 67-bit stream window that starts at that position. Each transaction
// produces exactly one result transaction on the master stream: decoded
// value, payload size, bits consumed and next bit position.
//
// An accepted transaction passes in order through an input stage, a decode
// stage (opcode table, header parse, payload alignment) and an output stage
// (payload extension and position add) before m_axis_tvalid rises. One
// transaction enters per cycle; throughput is one result per cycle while the
// receiver takes it.
//
// When the receiver stalls, the output stage holds its result and bubbles
// in front of it are squeezed out; s_axis_tready drops once all three stages
// are full. Nothing is dropped or repeated. Reset empties all stages.
module prefix_coded_instruction_field_decoder #(
    parameter int POSITION_WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: bit_position, window_first[63:0], window_rest[2:0], zero fill
    input  logic [((POSITION_WIDTH + 67 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: mode[3:0]
    input  logic [3:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: field_value[63:0], payload_size[6:0], bits_consumed[6:0],
    //        next_position, zero fill
    output logic [((POSITION_WIDTH + 78 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int PW    = POSITION_WIDTH;
    localparam int IN_W  = ((PW + 67 + 7) / 8) * 8;
    localparam int OUT_W = ((PW + 78 + 7) / 8) * 8;

    logic                         s1_valid_reg;
    logic [3:0]                   s1_mode_reg;
    logic [PW-1:0]                s1_pos_reg;
    logic [pcifd_pkg::WIN_W-1:0]  s1_win_reg;

    logic                         s2_valid_reg;
    pcifd_pkg::decode_t           s2_dec_reg;
    logic [PW-1:0]                s2_pos_reg;

    logic                         s3_valid_reg;
    logic [63:0]                  s3_value_reg;
    logic [6:0]                   s3_psize_reg;
    logic [6:0]                   s3_used_reg;
    logic [PW-1:0]                s3_pos_reg;

    pcifd_pkg::decode_t           s2_dec_next;
    logic [63:0]                  s3_value_next;
    logic [PW-1:0]                s3_pos_next;

    logic rdy1;
    logic rdy2;
    logic rdy3;

    assign rdy3 = !s3_valid_reg || m_axis_tready;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;

    assign s_axis_tready = rdy1;

    pcifd_decode u_decode (
        .mode   (s1_mode_reg),
        .window (s1_win_reg),
        .dec    (s2_dec_next)
    );

    always_comb
    begin
        unique case (s2_dec_reg.psize)
            pcifd_pkg::SZ_BIT:
                s3_value_next = s2_dec_reg.sign_ext ? {64{s2_dec_reg.raw[63]}}
                                                    : {63'b0, s2_dec_reg.raw[63]};
            pcifd_pkg::SZ_BYTE:
                s3_value_next = {{56{s2_dec_reg.sign_ext & s2_dec_reg.raw[63]}},
                                 s2_dec_reg.raw[63:56]};
            pcifd_pkg::SZ_HALF:
                s3_value_next = {{48{s2_dec_reg.sign_ext & s2_dec_reg.raw[63]}},
                                 s2_dec_reg.raw[63:48]};
            pcifd_pkg::SZ_WORD:
                s3_value_next = {{32{s2_dec_reg.sign_ext & s2_dec_reg.raw[63]}},
                                 s2_dec_reg.raw[63:32]};
            pcifd_pkg::SZ_DWORD:
                s3_value_next = s2_dec_reg.raw;
            default:
                s3_value_next = {57'b0, s2_dec_reg.small_val};
        endcase
    end

    assign s3_pos_next = s2_pos_reg + PW'(s2_dec_reg.used);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= s_axis_tvalid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && rdy1)
        begin
            s1_mode_reg <= s_axis_tuser;
            s1_pos_reg  <= s_axis_tdata[PW-1:0];
            s1_win_reg  <= {s_axis_tdata[PW+63:PW], s_axis_tdata[PW+66:PW+64]};
        end
        if (s1_valid_reg && rdy2)
        begin
            s2_dec_reg <= s2_dec_next;
            s2_pos_reg <= s1_pos_reg;
        end
        if (s2_valid_reg && rdy3)
        begin
            s3_value_reg <= s3_value_next;
            s3_psize_reg <= s2_dec_reg.psize;
            s3_used_reg  <= s2_dec_reg.used;
            s3_pos_reg   <= s3_pos_next;
        end
    end

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = OUT_W'({s3_pos_reg, s3_used_reg, s3_psize_reg, s3_value_reg});

    // payload fields always sit behind a nonempty header
    a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && s3_psize_reg != 7'd0) |-> (s3_used_reg > s3_psize_reg))
        else $error("payload size not below bits consumed");

    // fixed-length fields never exceed seven bits
    a_short_field: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && s3_psize_reg == 7'd0) |-> (s3_used_reg <= 7'd7))
        else $error("short field longer than seven bits");

    // an accepted transaction lands in the input stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> s1_valid_reg)
        else $error("accepted transaction lost at input stage");

    // hold the decode stage while the output stage is blocked
    a_decode_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !rdy3) |=> (s2_valid_reg && $stable(s2_dec_reg)))
        else $error("decode stage changed during stall");

endmodule
